[design/arp_pkg.sv]
package arp_pkg;

    // table geometry
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int ACT_W  = 2;
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int PORT_W = 8;
    localparam int HWT_W  = 16;

    // stream beat widths
    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 80;

    typedef enum logic [ACT_W-1:0] {
        ACT_LEARN_REQ = 2'd0,
        ACT_LEARN_REP = 2'd1,
        ACT_LOOKUP    = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [HWT_W-1:0]  hwt;
    } entry_t;

    // status of the scan unit toward the sequencer and datapath
    typedef struct packed {
        logic             done;
        logic             match;
        logic [IDX_W-1:0] match_idx;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
    } scan_stat_t;

    // controls from the sequencer
    typedef struct packed {
        logic start;
        logic wr_en;
        logic load;
        logic in_ready;
        logic out_valid;
    } seq_ctrl_t;

    function automatic logic act_is_learn(logic [ACT_W-1:0] a);
        return (a == ACT_LEARN_REQ) || (a == ACT_LEARN_REP);
    endfunction

endpackage

[design/arp_entry_mem.sv]
module arp_entry_mem
    import arp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_entry,
    output logic             rd_valid,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_entry
);

    entry_t             mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    entry_t             rd_entry_reg;
    logic               rd_valid_reg;

    // entry words, no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    // valid flags cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

[design/arp_scan_unit.sv]
module arp_scan_unit
    import arp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [IP_W-1:0]  key,
    output logic [IDX_W-1:0] rd_addr,
    input  entry_t           rd_entry,
    input  logic             rd_valid,
    output scan_stat_t       stat,
    output entry_t           match_entry
);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             live_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             done_reg;
    logic             match_reg;
    logic [IDX_W-1:0] match_idx_reg;
    entry_t           match_entry_reg;
    logic             free_ok_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic issue;
    logic hit_now;
    logic last_cmp;

    assign issue    = busy_reg && (cnt_reg < CNT_W'(ENTRIES));
    assign rd_addr  = cnt_reg[IDX_W-1:0];
    // the one shared comparator
    assign hit_now  = live_reg && rd_valid && (rd_entry.ip == key);
    assign last_cmp = live_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            live_reg    <= 1'b0;
            done_reg    <= 1'b0;
            match_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
            cnt_reg     <= '0;
        end else if (start) begin
            busy_reg    <= 1'b1;
            live_reg    <= 1'b0;
            done_reg    <= 1'b0;
            match_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
            cnt_reg     <= '0;
        end else if (busy_reg) begin
            live_reg <= issue;
            if (issue) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (hit_now) begin
                match_reg <= 1'b1;
                busy_reg  <= 1'b0;
                done_reg  <= 1'b1;
            end else begin
                if (live_reg && !rd_valid && !free_ok_reg) begin
                    free_ok_reg <= 1'b1;
                end
                if (last_cmp) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end else begin
            live_reg <= 1'b0;
        end
    end

    // payload side of the scan
    always_ff @(posedge aclk) begin
        if (issue) begin
            cmp_idx_reg <= cnt_reg[IDX_W-1:0];
        end
        if (busy_reg && hit_now) begin
            match_idx_reg   <= cmp_idx_reg;
            match_entry_reg <= rd_entry;
        end
        if (busy_reg && !hit_now && live_reg && !rd_valid && !free_ok_reg) begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    assign stat.done      = done_reg;
    assign stat.match     = match_reg;
    assign stat.match_idx = match_idx_reg;
    assign stat.free_ok   = free_ok_reg;
    assign stat.free_idx  = free_idx_reg;
    assign match_entry    = match_entry_reg;

endmodule

[design/arp_seq.sv]
module arp_seq
    import arp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             m_tready,
    input  logic [ACT_W-1:0] act,
    input  scan_stat_t       stat,
    output seq_ctrl_t        ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   act_known;
    logic   need_write;

    assign act_known  = act_is_learn(act) || (act == ACT_LOOKUP);
    assign need_write = act_is_learn(act) && (stat.match || stat.free_ok);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!act_known) begin
                    state_next = ST_RESULT;
                end else if (stat.done) begin
                    state_next = need_write ? ST_WRITE : ST_RESULT;
                end
            end
            ST_WRITE: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE: begin
                ctrl.in_ready = 1'b1;
                ctrl.start    = s_tvalid;
            end
            ST_SCAN: begin
                ctrl.load = !act_known || (stat.done && !need_write);
            end
            ST_WRITE: begin
                ctrl.wr_en = 1'b1;
                ctrl.load  = 1'b1;
            end
            ST_RESULT: begin
                ctrl.out_valid = 1'b1;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

endmodule

[design/arp_cache_table.sv]
// flow: an input beat starts a scan of every entry, which ends early when a valid entry
//   matches; an item that writes an entry passes the write state before its result
//   beat, and an unknown action goes to the result beat without waiting for the scan
// throughput: one item at a time, next input beat taken in the cycle after the result
//   beat leaves; the table scan reads one entry word per cycle through its one read port
// reset: aresetn synchronous active low, clears all entry valid flags, own_ip and the
//   sequencer; entry words are not cleared and need no clearing pass
module arp_cache_table
    import arp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // own_ip register write
    input  logic                cfg_wr_en,
    input  logic [IP_W-1:0]     cfg_wr_data,
    // input beat
    input  logic                s_tvalid,
    output logic                s_tready,
    // target_ip, sender_ip, sender_mac, arrival_port, hw_type
    input  logic [S_DATA_W-1:0] s_tdata,
    // action
    input  logic [ACT_W-1:0]    s_tuser,
    // result beat
    output logic                m_tvalid,
    input  logic                m_tready,
    // hit, found_mac, found_port, found_hw_type, table_full, reply_due,
    // request_due, zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    // own address register
    logic [IP_W-1:0] own_ip_reg;

    // latched item
    logic [ACT_W-1:0]  act_reg;
    logic [IP_W-1:0]   tip_reg;
    logic [IP_W-1:0]   key_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [PORT_W-1:0] port_reg;
    logic [HWT_W-1:0]  hwt_reg;

    // result beat register
    logic [M_DATA_W-1:0] m_tdata_reg;

    seq_ctrl_t  ctrl;
    scan_stat_t stat;
    entry_t     rd_entry;
    logic       rd_valid;
    entry_t     match_entry;
    entry_t     wr_entry;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    // input field slices
    logic [IP_W-1:0]   in_tip;
    logic [IP_W-1:0]   in_sip;
    logic [MAC_W-1:0]  in_mac;
    logic [PORT_W-1:0] in_port;
    logic [HWT_W-1:0]  in_hwt;

    assign in_tip  = s_tdata[31:0];
    assign in_sip  = s_tdata[63:32];
    assign in_mac  = s_tdata[111:64];
    assign in_port = s_tdata[119:112];
    assign in_hwt  = s_tdata[135:120];

    // result fields
    logic              r_learn;
    logic              r_lookup;
    logic              r_hit;
    logic [MAC_W-1:0]  r_mac;
    logic [PORT_W-1:0] r_port;
    logic [HWT_W-1:0]  r_hwt;
    logic              r_full;
    logic              r_reply;
    logic              r_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg <= '0;
        end else if (cfg_wr_en) begin
            own_ip_reg <= cfg_wr_data;
        end
    end

    // capture the item on its beat; a request keys on sender ip, the rest on target ip
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            act_reg  <= s_tuser;
            tip_reg  <= in_tip;
            key_reg  <= (s_tuser == ACT_LEARN_REQ) ? in_sip : in_tip;
            mac_reg  <= in_mac;
            port_reg <= in_port;
            hwt_reg  <= in_hwt;
        end
    end

    arp_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .act      (act_reg),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    arp_scan_unit u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (ctrl.start),
        .key         (key_reg),
        .rd_addr     (rd_addr),
        .rd_entry    (rd_entry),
        .rd_valid    (rd_valid),
        .stat        (stat),
        .match_entry (match_entry)
    );

    // refresh the matched entry, else fill the lowest free slot
    assign wr_addr       = stat.match ? stat.match_idx : stat.free_idx;
    assign wr_entry.ip   = key_reg;
    assign wr_entry.mac  = mac_reg;
    assign wr_entry.port = port_reg;
    assign wr_entry.hwt  = hwt_reg;

    arp_entry_mem u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid),
        .wr_en    (ctrl.wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry)
    );

    // an unknown action leaves every result field zero
    assign r_learn  = act_is_learn(act_reg);
    assign r_lookup = (act_reg == ACT_LOOKUP);
    assign r_hit    = (r_learn || r_lookup) && stat.match;
    assign r_mac    = (r_lookup && stat.match) ? match_entry.mac  : '0;
    assign r_port   = (r_lookup && stat.match) ? match_entry.port : '0;
    assign r_hwt    = (r_lookup && stat.match) ? match_entry.hwt  : '0;
    assign r_full   = r_learn && !stat.match && !stat.free_ok;
    assign r_reply  = (act_reg == ACT_LEARN_REQ) && (tip_reg == own_ip_reg);
    assign r_req    = r_lookup && !stat.match;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            m_tdata_reg <= {4'd0, r_req, r_reply, r_full, r_hwt, r_port, r_mac, r_hit};
        end
    end

    assign s_tready = ctrl.in_ready;
    assign m_tvalid = ctrl.out_valid;
    assign m_tdata  = m_tdata_reg;

endmodule

[design/arp_checker.sv]
module arp_checker
    import arp_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // one item in flight: no new input while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // an accepted input closes the input side for the scan
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after accept");

    // hit and request_due exclude each other, and so do hit and table_full
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && (m_tdata[75] || m_tdata[73])))
        else $error("hit together with request or full flag");

    // binding data appears only on a hit
    a_data_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[72:1] == '0))
        else $error("binding data without hit");

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed under stall");

endmodule

bind arp_cache_table arp_checker u_arp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/arp_result_checker.sv]
module arp_result_checker
    import arp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [IP_W-1:0]     cfg_wr_data,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [ACT_W-1:0]    s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  fail_count,
    output int                  pending,
    output int                  n_results,
    output int                  n_hits,
    output int                  n_full,
    output int                  n_reply,
    output int                  n_request
);

    // input beat layout, lowest bit first
    localparam int S_TIP  = 0;
    localparam int S_SIP  = S_TIP + IP_W;
    localparam int S_MAC  = S_SIP + IP_W;
    localparam int S_PORT = S_MAC + MAC_W;
    localparam int S_HWT  = S_PORT + PORT_W;

    // result beat layout, lowest bit first
    localparam int R_HIT   = 0;
    localparam int R_MAC   = R_HIT + 1;
    localparam int R_PORT  = R_MAC + MAC_W;
    localparam int R_HWT   = R_PORT + PORT_W;
    localparam int R_FULL  = R_HWT + HWT_W;
    localparam int R_REPLY = R_FULL + 1;
    localparam int R_REQ   = R_REPLY + 1;
    localparam int R_PAD   = R_REQ + 1;

    typedef struct packed {
        logic              hit;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [HWT_W-1:0]  hwt;
        logic              table_full;
        logic              reply_due;
        logic              request_due;
    } arp_result_t;

    logic [IP_W-1:0]   own_ip;
    logic              bind_valid [ENTRIES];
    logic [IP_W-1:0]   bind_ip    [ENTRIES];
    logic [MAC_W-1:0]  bind_mac   [ENTRIES];
    logic [PORT_W-1:0] bind_port  [ENTRIES];
    logic [HWT_W-1:0]  bind_hwt   [ENTRIES];

    arp_result_t expected_q[$];

    function automatic int find_binding(logic [IP_W-1:0] ip);
        for (int k = 0; k < ENTRIES; k++) begin
            if (bind_valid[k] && bind_ip[k] == ip)
                return k;
        end
        return -1;
    endfunction

    function automatic int first_free_slot();
        for (int k = 0; k < ENTRIES; k++) begin
            if (!bind_valid[k])
                return k;
        end
        return -1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("result %0d: %s", n_results, msg);
        fail_count++;
    endtask

    // update the table copy and queue the result this item must produce
    task automatic resolve_item(logic [ACT_W-1:0] act, logic [IP_W-1:0] tip,
                                logic [IP_W-1:0] sip, logic [MAC_W-1:0] mac,
                                logic [PORT_W-1:0] port, logic [HWT_W-1:0] hwt);
        arp_result_t r;
        logic [IP_W-1:0] key;
        int slot;
        r = '0;
        case (act)
            ACT_LEARN_REQ, ACT_LEARN_REP: begin
                key  = (act == ACT_LEARN_REQ) ? sip : tip;
                slot = find_binding(key);
                if (slot >= 0) begin
                    r.hit = 1'b1;
                end else begin
                    slot = first_free_slot();
                    if (slot < 0)
                        r.table_full = 1'b1;
                end
                if (slot >= 0) begin
                    bind_valid[slot] = 1'b1;
                    bind_ip[slot]    = key;
                    bind_mac[slot]   = mac;
                    bind_port[slot]  = port;
                    bind_hwt[slot]   = hwt;
                end
                if (act == ACT_LEARN_REQ && tip == own_ip)
                    r.reply_due = 1'b1;
            end
            ACT_LOOKUP: begin
                slot = find_binding(tip);
                if (slot >= 0) begin
                    r.hit  = 1'b1;
                    r.mac  = bind_mac[slot];
                    r.port = bind_port[slot];
                    r.hwt  = bind_hwt[slot];
                end else begin
                    r.request_due = 1'b1;
                end
            end
            default: ;
        endcase
        n_hits    += r.hit;
        n_full    += r.table_full;
        n_reply   += r.reply_due;
        n_request += r.request_due;
        expected_q.push_back(r);
    endtask

    task automatic check_result(logic [M_DATA_W-1:0] beat);
        arp_result_t want;
        want = expected_q.pop_front();
        if (beat[R_HIT] !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", beat[R_HIT], want.hit));
        if (beat[R_MAC +: MAC_W] !== want.mac)
            report_mismatch($sformatf("found_mac %h, want %h",
                                      beat[R_MAC +: MAC_W], want.mac));
        if (beat[R_PORT +: PORT_W] !== want.port)
            report_mismatch($sformatf("found_port %h, want %h",
                                      beat[R_PORT +: PORT_W], want.port));
        if (beat[R_HWT +: HWT_W] !== want.hwt)
            report_mismatch($sformatf("found_hw_type %h, want %h",
                                      beat[R_HWT +: HWT_W], want.hwt));
        if (beat[R_FULL] !== want.table_full)
            report_mismatch($sformatf("table_full %b, want %b",
                                      beat[R_FULL], want.table_full));
        if (beat[R_REPLY] !== want.reply_due)
            report_mismatch($sformatf("reply_due %b, want %b",
                                      beat[R_REPLY], want.reply_due));
        if (beat[R_REQ] !== want.request_due)
            report_mismatch($sformatf("request_due %b, want %b",
                                      beat[R_REQ], want.request_due));
        if (beat[M_DATA_W-1:R_PAD] !== '0)
            report_mismatch($sformatf("pad bits %h, want zero", beat[M_DATA_W-1:R_PAD]));
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
        n_results  = 0;
        n_hits     = 0;
        n_full     = 0;
        n_reply    = 0;
        n_request  = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            own_ip = '0;
            for (int k = 0; k < ENTRIES; k++)
                bind_valid[k] = 1'b0;
            expected_q.delete();
        end else begin
            if (cfg_wr_en)
                own_ip = cfg_wr_data;
            if (s_tvalid && s_tready)
                resolve_item(s_tuser, s_tdata[S_TIP +: IP_W], s_tdata[S_SIP +: IP_W],
                             s_tdata[S_MAC +: MAC_W], s_tdata[S_PORT +: PORT_W],
                             s_tdata[S_HWT +: HWT_W]);
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0)
                    report_mismatch("result beat with no result expected");
                else
                    check_result(m_tdata);
                n_results++;
            end
        end
        pending = expected_q.size();
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    import arp_pkg::*;

    // action code the block must ignore, outside the package enum
    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

    localparam int POOL_SIZE     = 96;   // more addresses than table slots, so it fills
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 325;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 80;   // a little more than a full scan
    localparam int CYCLE_LIMIT   = 1000000;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [IP_W-1:0]     cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;     // target_ip, sender_ip, sender_mac, arrival_port, hw_type
    logic [ACT_W-1:0]    s_tuser;     // action
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;     // hit, found_mac, found_port, found_hw_type,
                                      // table_full, reply_due, request_due, zero pad

    int fail_count;
    int pending;
    int n_results;
    int n_hits;
    int n_full;
    int n_reply;
    int n_request;

    // knobs shared by the sender, the receiver and the sequence
    int              tx_idle_pct;
    int              rx_stall_pct;
    bit              rx_hold_req;
    int              rx_hold_left;
    logic [IP_W-1:0] cur_own_ip;
    logic [IP_W-1:0] ip_pool [POOL_SIZE];
    int              n_items;
    int              n_cfg_writes;
    int              cycle_count;

    arp_cache_table u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    arp_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .pending     (pending),
        .n_results   (n_results),
        .n_hits      (n_hits),
        .n_full      (n_full),
        .n_reply     (n_reply),
        .n_request   (n_request)
    );

    // clock, period 10
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog on total run length
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off when asked for
    initial begin
        m_tready     = 1'b0;
        rx_hold_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_tready     <= 1'b0;
                rx_hold_left--;
            end else if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = HOLD_CYCLES;
                m_tready     <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // one beat on the input channel, called and returning at a falling edge
    task automatic send_item(logic [ACT_W-1:0] act, logic [IP_W-1:0] tip,
                             logic [IP_W-1:0] sip, logic [MAC_W-1:0] mac,
                             logic [PORT_W-1:0] port, logic [HWT_W-1:0] hwt);
        // random gaps before the beat
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {hwt, port, mac, sip, tip};
        do
            @(posedge aclk);
        while (!s_tready);
        n_items++;
        @(negedge aclk);
    endtask

    // drop valid and wait until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    // own_ip write, only while the block is idle
    task automatic write_own_ip(logic [IP_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cur_own_ip  = value;
        n_cfg_writes++;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly addresses from the pool so learns refresh and lookups hit
    function automatic logic [IP_W-1:0] pick_ip();
        if ($urandom_range(0, 99) < 85)
            return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        return IP_W'($urandom);
    endfunction

    task automatic send_random_item();
        logic [ACT_W-1:0] act;
        logic [IP_W-1:0]  tip;
        logic [IP_W-1:0]  sip;
        logic [MAC_W-1:0] mac;
        int               roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            act = ACT_LEARN_REQ;
        else if (roll < 55)
            act = ACT_LEARN_REP;
        else if (roll < 96)
            act = ACT_LOOKUP;
        else
            act = ACT_UNKNOWN;
        tip = pick_ip();
        sip = pick_ip();
        // aim some requests at this node so a reply comes due
        if (act == ACT_LEARN_REQ && $urandom_range(0, 3) == 0)
            tip = cur_own_ip;
        mac[MAC_W-1:32] = 16'($urandom);
        mac[31:0]       = 32'($urandom);
        roll = $urandom_range(0, 31);
        if (roll == 0)
            mac = '0;
        else if (roll == 1)
            mac = '1;
        send_item(act, tip, sip, mac, PORT_W'($urandom), HWT_W'($urandom));
    endtask

    initial begin
        logic [IP_W-1:0] phase_ip [PHASES];

        // every input known from time zero
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        rx_hold_req  = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        cur_own_ip   = '0;    // own_ip after reset
        n_items      = 0;
        n_cfg_writes = 0;

        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
            ip_pool[k] = IP_W'($urandom);

        // own_ip per phase, both extremes among them
        phase_ip[0] = '1;
        phase_ip[1] = ip_pool[7];
        phase_ip[2] = '0;
        phase_ip[3] = IP_W'($urandom);
        phase_ip[4] = ip_pool[30];
        phase_ip[5] = 32'h0A00_0001;

        // hold reset from time zero, then release it once
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, sender and receiver never idle
        // request aimed at address zero, own_ip still at its reset value
        send_item(ACT_LEARN_REQ, '0, 32'h0A00_0063, 48'h0200_0000_0001, 8'd1, 16'd1);
        wait_drained();
        write_own_ip(32'hC0A8_0001);
        // lookup of a key not in the table
        send_item(ACT_LOOKUP, '0, '0, '0, '0, '0);
        // learn from request with key zero, reply due
        send_item(ACT_LEARN_REQ, 32'hC0A8_0001, '0, 48'h0200_0000_0002, 8'd2, 16'd1);
        // all-ones key and data
        send_item(ACT_LEARN_REQ, '0, '1, '1, '1, '1);
        // learn from reply keys on the target address, all-zero data
        send_item(ACT_LEARN_REP, 32'hC0A8_0002, '1, '0, '0, '0);
        send_item(ACT_LOOKUP, '0, '1, '1, '1, '1);
        send_item(ACT_LOOKUP, '1, '0, '0, '0, '0);
        send_item(ACT_LOOKUP, 32'hC0A8_0002, '0, '0, '0, '0);
        send_item(ACT_LOOKUP, 32'h0A00_0063, '0, '0, '0, '0);
        // refresh of an existing binding
        send_item(ACT_LEARN_REP, '0, 32'h1234_5678, 48'hA5A5_5A5A_F00F, 8'h80, 16'h8000);
        send_item(ACT_LOOKUP, '0, '0, '0, '0, '0);
        // refresh through a request, reply due again
        send_item(ACT_LEARN_REQ, 32'hC0A8_0001, '1, 48'h8000_0000_0000, 8'h7F, 16'h7FFF);
        send_item(ACT_LOOKUP, '1, '0, '0, '0, '0);
        // unknown action must be ignored and answer all zero
        send_item(ACT_UNKNOWN, '1, '1, '1, '1, '1);
        send_item(ACT_UNKNOWN, 32'h0A00_0063, '0, '0, '0, '0);
        send_item(ACT_LOOKUP, 32'hC0A8_0001, '0, '0, '0, '0);
        // reply whose target is own_ip, no reply due on a reply
        send_item(ACT_LEARN_REP, 32'hC0A8_0001, '0, 48'h0000_0000_0001, 8'd3, 16'd6);
        send_item(ACT_LOOKUP, 32'hC0A8_0001, '0, '0, '0, '0);

        // random phases, each with its own own_ip; the idling pattern changes every two phases
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_own_ip(phase_ip[ph]);
            if (ph < 2) begin
                tx_idle_pct  = 38;
                rx_stall_pct = 61;
            end else if (ph < 4) begin
                tx_idle_pct  = 61;
                rx_stall_pct = 38;
            end else begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // long receiver hold-off while the sender keeps offering
                if (ph == 1 && i == 100)
                    rx_hold_req = 1'b1;
                // sender pause until the block has nothing left in flight
                if (ph == 3 && i == 150)
                    wait_drained();
                send_random_item();
            end
        end

        // drain and let the block settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items and %0d results over %0d own_ip settings",
                 n_items, n_results, n_cfg_writes + 1);
        $display("hits %0d, dropped on full table %0d, replies due %0d, requests due %0d",
                 n_hits, n_full, n_reply, n_request);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
design/arp_pkg.sv
design/arp_entry_mem.sv
design/arp_scan_unit.sv
design/arp_seq.sv
design/arp_cache_table.sv
design/arp_checker.sv
tb/arp_result_checker.sv
tb/tb_top.sv
